@@ src/fcfs_schedule_timing_defines.svh @@
// assertion macros shared by the scheduler rtl
`ifndef FCFS_SCHEDULE_TIMING_DEFINES_SVH
`define FCFS_SCHEDULE_TIMING_DEFINES_SVH

// same-cycle implication, checked on every rising clock edge out of reset
`define FST_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("scheduler check failed");

// next-cycle implication, checked on every rising clock edge out of reset
`define FST_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("scheduler check failed");

`endif

@@ src/fst_pkg.sv @@
// ----------------------------------------------------------------------------
// fst_pkg
// types and constants shared by the first-come-first-served timing block
// ----------------------------------------------------------------------------
package fst_pkg;

   localparam int ID_W       = 8;
   localparam int TICK_W     = 16;
   localparam int TIME_W     = 21;
   localparam int SUM_W      = 25;
   localparam int MAX_JOBS_DEF = 16;

   // one input beat
   typedef struct packed {
      logic [ID_W-1:0]   job_id;
      logic [TICK_W-1:0] arrival_time;
      logic [TICK_W-1:0] burst_time;
      logic              last_item;
   } req_type;

   // one result beat
   typedef struct packed {
      logic [ID_W-1:0]   out_job_id;
      logic [TICK_W-1:0] out_arrival;
      logic [TICK_W-1:0] out_burst;
      logic [TIME_W-1:0] completion_time;
      logic [TIME_W-1:0] waiting_time;
      logic [TIME_W-1:0] turnaround_time;
      logic [SUM_W-1:0]  total_waiting;
      logic [SUM_W-1:0]  total_turnaround;
      logic              batch_end;
      logic              overflowed;
   } rsp_type;

   // job held by one cell of the sort chain
   typedef struct packed {
      logic [ID_W-1:0]   id;
      logic [TICK_W-1:0] arr;
      logic [TICK_W-1:0] bur;
   } job_type;

   // chain control
   typedef struct packed {
      logic insert;
      logic pop;
   } cell_ctrl_type;

   // timing unit control
   typedef struct packed {
      logic calc;
      logic acc;
      logic batch_end;
      logic overflowed;
   } timing_ctrl_type;

endpackage

@@ src/fcfs_schedule_timing.sv @@
// after the last item, each stored job passes from the chain head through a calc and an acc
// state, and a result strobe follows each acc; busy stays high while the stored jobs are processed.
// when idle, the insertion chain sorts during loading, one job per cycle, so no sort pass follows.
// synchronous reset empties the chain and clears count, overflow flag and running totals.
// results cannot be stalled: each is shown for one cycle under rsp_strobe.
// ----------------------------------------------------------------------------
// fcfs_schedule_timing
// first-come-first-served batch scheduler: sorted chain plus timing unit
// ----------------------------------------------------------------------------
`include "fcfs_schedule_timing_defines.svh"

module fcfs_schedule_timing #(
   parameter int MAX_JOBS = fst_pkg::MAX_JOBS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  fst_pkg::req_type req_data,
   output fst_pkg::rsp_type rsp_data,
   output logic             rsp_strobe
);

   localparam int CW = $clog2(MAX_JOBS + 1);

   typedef enum logic [1:0] {
      ST_LOAD,
      ST_CALC,
      ST_ACC
   } state_type;

   state_type        state_ff, state_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             dropped_ff, dropped_in;

   fst_pkg::job_type          new_job;
   fst_pkg::job_type          jobs  [MAX_JOBS];
   logic                      valids[MAX_JOBS];
   logic                      shifts[MAX_JOBS];
   fst_pkg::cell_ctrl_type    cctl;
   fst_pkg::timing_ctrl_type  tctl;
   logic                      take;
   logic                      full;

   assign busy = (state_ff != ST_LOAD);
   assign take = start && !busy;
   assign full = (count_ff == CW'(MAX_JOBS));

   assign new_job.id  = req_data.job_id;
   assign new_job.arr = req_data.arrival_time;
   assign new_job.bur = req_data.burst_time;

   assign cctl.insert = take && !full;
   assign cctl.pop    = (state_ff == ST_ACC);

   assign tctl.calc       = (state_ff == ST_CALC);
   assign tctl.acc        = (state_ff == ST_ACC);
   assign tctl.batch_end  = (count_ff == CW'(1));
   assign tctl.overflowed = dropped_ff;

   // sort chain
   for (genvar i = 0; i < MAX_JOBS; i++) begin : g_cell
      fst_pkg::job_type left_job, right_job;
      logic             left_valid, left_shift, right_valid;

      if (i == 0) begin : g_head
         assign left_job   = new_job;
         assign left_valid = 1'b0;
         assign left_shift = 1'b0;
      end else begin : g_mid
         assign left_job   = jobs[i-1];
         assign left_valid = valids[i-1];
         assign left_shift = shifts[i-1];
      end

      if (i == MAX_JOBS - 1) begin : g_tail
         assign right_job   = jobs[i];
         assign right_valid = 1'b0;
      end else begin : g_body
         assign right_job   = jobs[i+1];
         assign right_valid = valids[i+1];
      end

      fst_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctrl        (cctl),
         .new_job     (new_job),
         .left_job    (left_job),
         .left_valid  (left_valid),
         .left_shift  (left_shift),
         .right_job   (right_job),
         .right_valid (right_valid),
         .job         (jobs[i]),
         .valid       (valids[i]),
         .shift_out   (shifts[i])
      );
   end

   // completion arithmetic on the chain head
   fst_timing u_timing (
      .clock      (clock),
      .reset      (reset),
      .tctl       (tctl),
      .head       (jobs[0]),
      .rsp_data   (rsp_data),
      .rsp_strobe (rsp_strobe)
   );

   // batch sequencing
   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      dropped_in = dropped_ff;
      unique case (state_ff)
         ST_LOAD: begin
            if (take) begin
               if (full) begin
                  dropped_in = 1'b1;
               end else begin
                  count_in = count_ff + CW'(1);
               end
               if (req_data.last_item) begin
                  state_in = ST_CALC;
               end
            end
         end
         ST_CALC: begin
            state_in = ST_ACC;
         end
         ST_ACC: begin
            count_in = count_ff - CW'(1);
            if (tctl.batch_end) begin
               dropped_in = 1'b0;
               state_in   = ST_LOAD;
            end else begin
               state_in = ST_CALC;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_LOAD;
         count_ff   <= '0;
         dropped_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         count_ff   <= count_in;
         dropped_ff <= dropped_in;
      end
   end

   // checks
   `FST_ASSERT_NEXT(a_last_goes_busy, take && req_data.last_item, busy)
   `FST_ASSERT_SAME(a_end_frees, rsp_strobe && rsp_data.batch_end, !busy && count_ff == '0)
   `FST_ASSERT_SAME(a_head_valid, state_ff == ST_CALC, valids[0])
   `FST_ASSERT_SAME(a_comp_order, rsp_strobe,
                    rsp_data.completion_time >= rsp_data.turnaround_time)

endmodule

@@ src/fst_cell.sv @@
// ----------------------------------------------------------------------------
// fst_cell
// one slot of the insertion chain: keeps jobs ordered by arrival, stable
// ----------------------------------------------------------------------------
module fst_cell (
   input  logic                   clock,
   input  logic                   reset,
   input  fst_pkg::cell_ctrl_type ctrl,
   input  fst_pkg::job_type       new_job,
   input  fst_pkg::job_type       left_job,
   input  logic                   left_valid,
   input  logic                   left_shift,
   input  fst_pkg::job_type       right_job,
   input  logic                   right_valid,
   output fst_pkg::job_type       job,
   output logic                   valid,
   output logic                   shift_out
);

   fst_pkg::job_type job_ff, job_in;
   logic             valid_ff, valid_in;

   // equal arrivals stay ahead of the new job, so only strictly later ones move
   assign shift_out = !valid_ff || (job_ff.arr > new_job.arr);

   // insert moves toward the tail, pop moves toward the head
   always_comb begin
      job_in   = job_ff;
      valid_in = valid_ff;
      if (ctrl.pop) begin
         job_in   = right_job;
         valid_in = right_valid;
      end else if (ctrl.insert && shift_out) begin
         if (left_shift) begin
            job_in   = left_job;
            valid_in = left_valid;
         end else begin
            job_in   = new_job;
            valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      job_ff <= job_in;
   end

   assign job   = job_ff;
   assign valid = valid_ff;

endmodule

@@ src/fst_timing.sv @@
// ----------------------------------------------------------------------------
// fst_timing
// two-step completion, waiting and turnaround arithmetic with running totals
// ----------------------------------------------------------------------------
module fst_timing (
   input  logic                     clock,
   input  logic                     reset,
   input  fst_pkg::timing_ctrl_type tctl,
   input  fst_pkg::job_type         head,
   output fst_pkg::rsp_type         rsp_data,
   output logic                     rsp_strobe
);

   localparam int TW = fst_pkg::TIME_W;
   localparam int SW = fst_pkg::SUM_W;

   logic [TW-1:0]    prev_ff, prev_in;
   logic [SW-1:0]    sum_wait_ff, sum_wait_in;
   logic [SW-1:0]    sum_tat_ff, sum_tat_in;
   logic [TW-1:0]    start_ff, start_in;
   logic [TW-1:0]    wait_ff, wait_in;
   fst_pkg::job_type job_ff;
   fst_pkg::rsp_type rsp_ff, rsp_in;
   logic             strobe_ff;

   logic [TW-1:0] arr_ext;
   logic [TW:0]   comp_sum, tat_sum;
   logic [TW-1:0] comp, tat;
   logic [SW:0]   sw_sum, st_sum;

   // first step: service start and waiting time
   always_comb begin
      arr_ext  = TW'(head.arr);
      start_in = (prev_ff > arr_ext) ? prev_ff : arr_ext;
      wait_in  = start_in - arr_ext;
   end

   // second step: completion, turnaround and totals, all saturating
   always_comb begin
      comp_sum = {1'b0, start_ff} + (TW+1)'(job_ff.bur);
      comp     = comp_sum[TW] ? {TW{1'b1}} : comp_sum[TW-1:0];
      tat_sum  = {1'b0, wait_ff} + (TW+1)'(job_ff.bur);
      tat      = tat_sum[TW] ? {TW{1'b1}} : tat_sum[TW-1:0];
      sw_sum   = {1'b0, sum_wait_ff} + (SW+1)'(wait_ff);
      st_sum   = {1'b0, sum_tat_ff} + (SW+1)'(tat);

      rsp_in.out_job_id       = job_ff.id;
      rsp_in.out_arrival      = job_ff.arr;
      rsp_in.out_burst        = job_ff.bur;
      rsp_in.completion_time  = comp;
      rsp_in.waiting_time     = wait_ff;
      rsp_in.turnaround_time  = tat;
      rsp_in.total_waiting    = sw_sum[SW] ? {SW{1'b1}} : sw_sum[SW-1:0];
      rsp_in.total_turnaround = st_sum[SW] ? {SW{1'b1}} : st_sum[SW-1:0];
      rsp_in.batch_end        = tctl.batch_end;
      rsp_in.overflowed       = tctl.overflowed;

      // batch end returns the running state to zero
      if (tctl.batch_end) begin
         prev_in     = '0;
         sum_wait_in = '0;
         sum_tat_in  = '0;
      end else begin
         prev_in     = comp;
         sum_wait_in = rsp_in.total_waiting;
         sum_tat_in  = rsp_in.total_turnaround;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff     <= '0;
         sum_wait_ff <= '0;
         sum_tat_ff  <= '0;
         strobe_ff   <= 1'b0;
      end else begin
         strobe_ff <= tctl.acc;
         if (tctl.acc) begin
            prev_ff     <= prev_in;
            sum_wait_ff <= sum_wait_in;
            sum_tat_ff  <= sum_tat_in;
         end
      end
      if (tctl.calc) begin
         start_ff <= start_in;
         wait_ff  <= wait_in;
         job_ff   <= head;
      end
      if (tctl.acc) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_data   = rsp_ff;
   assign rsp_strobe = strobe_ff;

endmodule
